[sv/mdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

	localparam int WINDOW_SIZE_DEF = 8;

	localparam int DIST_W = 16;
	localparam int STATUS_W = 8;
	localparam int GAIN_W = 17;
	localparam int AVG_W = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_RANGING_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = 2'd1;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd19661;

	localparam logic [AVG_W-1:0] ROUND_HALF = 32'd32768;

endpackage

`default_nettype wire

[sv/median_ema_distance_filter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Distance filter: each measurement with status 0 is written into a ring of the
// last WINDOW_SIZE samples, the median of the filled entries (element n/2 of
// ascending order) is found, and it drives an exponential average whose gain
// is smoothing_gain (Q1.16); the output is the average rounded half up. A
// measurement with non-zero status returns the last output with
// sample_accepted low and leaves the filter alone; with ranging_enabled low a
// measurement is taken and dropped without a result. For a valid sample the
// ring RAM has one read port, so the filled entries are first copied out one
// by one; then the rank search checks one candidate per cycle until it finds
// the median, then come two multiply steps, an add and a rounding step. The
// first sample seeds the average and skips the second multiply and the add. A
// rejected sample goes straight to the output state; a dropped one leaves the
// block idle. The output register lets the result wait while the next
// measurement is taken in.
module median_ema_distance_filter #(
	parameter int WINDOW_SIZE = mdf_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [mdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mdf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [mdf_pkg::DIST_W-1:0]         distance_mm,
	input  wire logic [mdf_pkg::STATUS_W-1:0]       range_status,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [mdf_pkg::DIST_W-1:0]         filtered_distance,
	output logic                                    sample_accepted
);

	localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CW = $clog2(WINDOW_SIZE + 1);
	localparam int DW = mdf_pkg::DIST_W;
	localparam int GW = mdf_pkg::GAIN_W;
	localparam int VW = mdf_pkg::AVG_W;
	localparam int P1W = GW + DW;
	localparam int P2W = GW + VW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_WAIT  = 4'd2;
	localparam logic [3:0] ST_RANK  = 4'd3;
	localparam logic [3:0] ST_MUL1  = 4'd4;
	localparam logic [3:0] ST_MUL2  = 4'd5;
	localparam logic [3:0] ST_ADD   = 4'd6;
	localparam logic [3:0] ST_ROUND = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]    state_q;
	logic          enabled_q;
	logic [GW-1:0] gain_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] slot_q;
	logic          seeded_q;
	logic [VW-1:0] avg_q;
	logic [DW-1:0] held_q;
	logic          acc_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] cand_q;
	logic          rd_pend_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [DW-1:0] win_q [WINDOW_SIZE];
	logic [DW-1:0] med_q;
	logic [P1W-1:0] p1_q;
	logic [P2W-1:0] p2_q;
	logic          out_valid_q;
	logic [DW-1:0] out_dist_q;
	logic          out_acc_q;

	logic          in_xfer;
	logic          sample_ok;
	logic          ram_we;
	logic [DW-1:0] ram_rdata;
	logic          out_free;
	logic [CW-1:0] fill_next;
	logic [DW-1:0] cand_v;
	logic [CW-1:0] rank;
	logic [GW-1:0] gain_inv;
	logic [VW+1:0] sum;
	logic [VW:0]   rnd;
	logic [GW-1:0] cfg_gain;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign sample_ok = enabled_q && (range_status == '0);
	assign ram_we = in_xfer && sample_ok;
	assign out_free = !out_valid_q || !out_stall;
	assign fill_next = (fill_q == CW'(WINDOW_SIZE)) ? fill_q : fill_q + 1'b1;

	assign gain_inv = mdf_pkg::GAIN_ONE - gain_q;
	assign sum = {1'b0, p1_q} + (VW+2)'(p2_q[P2W-1:16]);
	assign rnd = {1'b0, avg_q} + {1'b0, mdf_pkg::ROUND_HALF};
	assign cfg_gain = (cfg_data > mdf_pkg::GAIN_ONE) ? mdf_pkg::GAIN_ONE : cfg_data;

	mdf_ram #(
		.WIDTH(DW),
		.DEPTH(WINDOW_SIZE)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(distance_mm),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// stable rank of the candidate among the filled entries
	always_comb begin
		cand_v = win_q[cand_q];
		rank = '0;
		for (int j = 0; j < WINDOW_SIZE; j++) begin
			if (CW'(j) < n_q && (win_q[j] < cand_v ||
					(win_q[j] == cand_v && AW'(j) < cand_q))) begin
				rank = rank + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			enabled_q <= 1'b0;
			gain_q <= mdf_pkg::GAIN_RESET;
			fill_q <= '0;
			slot_q <= '0;
			seeded_q <= 1'b0;
			avg_q <= '0;
			held_q <= '0;
			acc_q <= 1'b0;
			n_q <= '0;
			rd_idx_q <= '0;
			cand_q <= '0;
			rd_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					mdf_pkg::REG_RANGING_ENABLED: enabled_q <= cfg_data[0];
					mdf_pkg::REG_SMOOTHING_GAIN:  gain_q <= cfg_gain;
					default: ;
				endcase
			end

			rd_pend_s1 <= (state_q == ST_LOAD);

			// load a new result, or drop the old one once it transfers
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer && enabled_q) begin
						if (range_status != '0) begin
							acc_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							fill_q <= fill_next;
							n_q <= fill_next;
							slot_q <= (slot_q == AW'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
							rd_idx_q <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					if (CW'(rd_idx_q) == n_q - 1'b1) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					cand_q <= '0;
					state_q <= ST_RANK;
				end
				ST_RANK: begin
					if (rank == (n_q >> 1)) begin
						state_q <= ST_MUL1;
					end else begin
						cand_q <= cand_q + 1'b1;
					end
				end
				ST_MUL1: begin
					if (!seeded_q) begin
						avg_q <= {med_q, 16'h0000};
						seeded_q <= 1'b1;
						state_q <= ST_ROUND;
					end else begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					avg_q <= (sum[VW+1:VW] != 2'b00) ? '1 : sum[VW-1:0];
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					held_q <= rnd[VW] ? '1 : rnd[VW-1:16];
					acc_q <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_idx_q;
		if (rd_pend_s1) begin
			win_q[rd_addr_s1] <= ram_rdata;
		end
		if (state_q == ST_RANK) begin
			med_q <= cand_v;
		end
		if (state_q == ST_MUL1) begin
			p1_q <= P1W'(gain_q) * P1W'(med_q);
		end
		if (state_q == ST_MUL2) begin
			p2_q <= P2W'(gain_inv) * P2W'(avg_q);
		end
		if (state_q == ST_EMIT && out_free) begin
			out_dist_q <= held_q;
			out_acc_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_distance = out_dist_q;
	assign sample_accepted = out_acc_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_SIZE))
		else $error("fill count above window size");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(WINDOW_SIZE) |-> CW'(slot_q) == fill_q)
		else $error("write slot out of step with fill count while filling");

	a_rank_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RANK |-> CW'(cand_q) < n_q)
		else $error("median search ran past the filled entries");

	a_accepted_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_accepted |-> seeded_q)
		else $error("accepted result before the average was seeded");
`endif

endmodule

`default_nettype wire

[sv/mdf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import mdf_pkg::*;

	localparam int RING_DEPTH = WINDOW_SIZE_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 100;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              accepted;
	} reading_t;

	// median of the sample window feeding a fixed-point exponential average
	class filter_scoreboard;
		logic              enabled;
		logic [GAIN_W-1:0] gain;
		logic [DIST_W-1:0] ring [RING_DEPTH];
		int unsigned       fill;
		int unsigned       slot;
		logic [AVG_W-1:0]  average_q16;
		logic              seeded;
		logic [DIST_W-1:0] held;
		reading_t          readings_q[$];
		int                errors;

		function new();
			enabled = 1'b0;
			gain = GAIN_RESET;
			fill = 0;
			slot = 0;
			average_q16 = '0;
			seeded = 1'b0;
			held = '0;
			errors = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_RANGING_ENABLED: enabled = data[0];
				REG_SMOOTHING_GAIN: gain = (data > GAIN_ONE) ? GAIN_ONE : data;
				default: ;
			endcase
		endfunction

		function logic [DIST_W-1:0] window_median();
			logic [DIST_W-1:0] sorted [RING_DEPTH];
			logic [DIST_W-1:0] v;
			int j;
			for (int i = 0; i < fill; i++) begin
				v = ring[i];
				j = i;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
			end
			return sorted[fill/2];
		endfunction

		function void note_measurement(logic [DIST_W-1:0] sample_mm,
				logic [STATUS_W-1:0] status);
			logic [DIST_W-1:0] med;
			longint unsigned g;
			longint unsigned w;
			longint unsigned sum;
			longint unsigned rounded;
			if (!enabled)
				return;
			if (status != '0) begin
				readings_q.push_back('{held, 1'b0});
				return;
			end
			if (fill < RING_DEPTH) begin
				ring[fill] = sample_mm;
				fill++;
			end else begin
				ring[slot] = sample_mm;
			end
			slot = (slot + 1) % RING_DEPTH;
			med = window_median();
			if (!seeded) begin
				average_q16 = {med, 16'h0000};
				seeded = 1'b1;
			end else begin
				g = gain;
				w = GAIN_ONE - gain;
				sum = ((g * med) << 16) + w * average_q16;
				sum = sum >> 16;
				if (sum > 64'hFFFF_FFFF)
					sum = 64'hFFFF_FFFF;
				average_q16 = sum[AVG_W-1:0];
			end
			rounded = average_q16;
			rounded = (rounded + ROUND_HALF) >> 16;
			if (rounded > 64'hFFFF)
				rounded = 64'hFFFF;
			held = rounded[DIST_W-1:0];
			readings_q.push_back('{held, 1'b1});
		endfunction

		function int waiting();
			return readings_q.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(logic [DIST_W-1:0] sample_mm, logic accepted);
			reading_t want;
			if (readings_q.size() == 0) begin
				report($sformatf("unexpected result distance %0d accepted %0b",
					sample_mm, accepted));
				return;
			end
			want = readings_q.pop_front();
			if (sample_mm !== want.distance)
				report($sformatf("filtered_distance %0d, want %0d",
					sample_mm, want.distance));
			if (accepted !== want.accepted)
				report($sformatf("sample_accepted %0b, want %0b", accepted, want.accepted));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [DIST_W-1:0]      distance_mm;
	logic [STATUS_W-1:0]    range_status;
	logic                   out_valid;
	logic                   out_stall;
	logic [DIST_W-1:0]      filtered_distance;
	logic                   sample_accepted;

	filter_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int holdoff_left = 0;
	int cycles = 0;
	logic [DIST_W-1:0] track_mm = 16'd1500;

	median_ema_distance_filter u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.distance_mm       (distance_mm),
		.range_status      (range_status),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_distance (filtered_distance),
		.sample_accepted   (sample_accepted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// result side: check each transfer, then pick the stall for the next edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(filtered_distance, sample_accepted);
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// valid stays high after a transfer, so back-to-back items keep it asserted
	task automatic send_item(input logic [DIST_W-1:0] sample_mm,
			input logic [STATUS_W-1:0] status);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		distance_mm <= sample_mm;
		range_status <= status;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_measurement(sample_mm, status);
	endtask

	task automatic send_random();
		logic [DIST_W-1:0] sample_mm;
		logic [STATUS_W-1:0] status;
		if ($urandom_range(31) == 0)
			track_mm = 16'($urandom);
		case ($urandom_range(9))
			0: sample_mm = 16'($urandom);
			1: sample_mm = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: sample_mm = 16'(track_mm + $urandom_range(64) - 32);
		endcase
		status = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : 8'd0;
		send_item(sample_mm, status);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// dropped items give no result, so allow the block to finish one after the queue drains
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.waiting() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		distance_mm = '0;
		range_status = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ranging off after reset: items are swallowed
		send_item(16'd500, 8'd0);
		send_item(16'd501, 8'd3);
		settle();
		write_reg(REG_RANGING_ENABLED, 17'd1);

		// rejected before seeding, then seed and fill the ring past wrap
		send_item(16'd1234, 8'd7);
		send_item(16'hFFFF, 8'd0);
		send_item(16'd0, 8'd0);
		send_item(16'd0, 8'd255);
		send_item(16'd1, 8'd0);
		send_item(16'd300, 8'd0);
		send_item(16'd42, 8'd0);
		send_item(16'd7, 8'd0);
		send_item(16'd9000, 8'd0);
		send_item(16'hFFFF, 8'd0);
		send_item(16'hFFFF, 8'd0);
		send_item(16'd100, 8'd128);
		send_item(16'd0, 8'd0);
		send_item(16'd5000, 8'd1);
		settle();

		// gain extremes; above one saturates
		write_reg(REG_SMOOTHING_GAIN, 17'd0);
		send_item(16'd1000, 8'd0);
		send_item(16'd2000, 8'd0);
		settle();
		write_reg(REG_SMOOTHING_GAIN, GAIN_ONE);
		send_item(16'd300, 8'd0);
		send_item(16'hFFFF, 8'd0);
		settle();
		write_reg(REG_SMOOTHING_GAIN, 17'h1FFFF);
		send_item(16'd12345, 8'd0);
		send_item(16'd54321, 8'd9);
		settle();
		write_reg(REG_SPARE_A, 17'h1FFFF);
		write_reg(REG_SPARE_B, 17'd0);
		write_reg(REG_SMOOTHING_GAIN, 17'd1);
		send_item(16'd40000, 8'd0);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 83; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 83; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			if (p == 3)
				write_reg(REG_SMOOTHING_GAIN, 17'($urandom));
			else
				write_reg(REG_SMOOTHING_GAIN, 17'($urandom_range(GAIN_ONE)));
			repeat (100) send_random();
			settle();
		end

		write_reg(REG_RANGING_ENABLED, 17'd0);
		repeat (20) send_random();
		settle();
		write_reg(REG_RANGING_ENABLED, 17'd1);
		write_reg(REG_SMOOTHING_GAIN, GAIN_RESET);

		// long output hold-off while items keep coming, so the input backs up
		idle_pct = 0;
		stall_pct = 20;
		holdoff_left = 400;
		repeat (30) send_random();
		settle();

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
